// ----- hw/rtl/mbrs_pkg.sv -----
// Shared types, constants and CRC helper for the Modbus RTU slave frame handler.
package mbrs_pkg;
	localparam int FRAME_BYTES = 8;
	localparam int BANK_REGS = 16;
	localparam int BANK_AW = $clog2(BANK_REGS);
	localparam int MAX_REPLY_WORDS = 16;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [7:0] FN_READ = 8'h03;
	localparam logic [7:0] FN_WRITE = 8'h06;
	localparam logic [7:0] BCAST_ADDR = 8'h00;

	localparam logic [1:0] REG_DEV_ADDR = 2'd0;
	localparam logic [1:0] REG_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_MAX_READ = 2'd2;
	localparam logic [1:0] REG_READ_LIM = 2'd3;

	typedef logic [7:0] frame_t [FRAME_BYTES];

	typedef struct packed {
		logic [7:0] len;
		logic [FRAME_BYTES*8-1:0] bytes;
	} job_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] d);
		logic [15:0] c;
		c = crc_in ^ {8'h00, d};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction
endpackage

// ----- hw/rtl/mbrs_front.sv -----
// Front end: gathers received bytes, tracks line silence and issues frame jobs.
module mbrs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        device_address,
	input  logic [15:0]       timeout_limit,
	input  logic              push,
	output logic              full,
	input  logic              mode,
	input  logic [7:0]        rx_byte,
	input  logic              end_of_chunk,
	output logic              job_push,
	output mbrs_pkg::job_t    job,
	input  logic              job_full
);
	import mbrs_pkg::*;

	logic [7:0]  len_q;
	logic [7:0]  store_q [FRAME_BYTES];
	logic [15:0] silence_q;
	logic        timed_out_q;

	logic        accept;
	logic [7:0]  len_inc;
	logic [7:0]  len_byte;
	logic        to_next;
	logic        fire;
	logic [7:0]  store_n [FRAME_BYTES];

	assign full = job_full;
	assign accept = push && !job_full;

	always_comb begin
		len_inc = (len_q < 8'd255) ? len_q + 8'd1 : len_q;
		len_byte = len_inc;
		if (len_inc == 8'd1 && rx_byte != device_address && rx_byte != BCAST_ADDR) begin
			len_byte = 8'd0;
		end
		for (int i = 0; i < FRAME_BYTES; i++) begin
			store_n[i] = store_q[i];
		end
		if (len_q < 8'(FRAME_BYTES)) begin
			store_n[len_q[2:0]] = rx_byte;
		end
		to_next = timed_out_q || (silence_q > timeout_limit);
		if (!mode) begin
			fire = end_of_chunk && (len_byte != 8'd0);
			job.len = len_byte;
		end else begin
			fire = to_next && (len_q != 8'd0);
			job.len = len_q;
		end
		for (int i = 0; i < FRAME_BYTES; i++) begin
			job.bytes[i*8 +: 8] = mode ? store_q[i] : store_n[i];
		end
	end

	assign job_push = accept && fire;

	always_ff @(posedge clk) begin
		if (accept && !mode) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				store_q[i] <= store_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 8'd0;
			silence_q <= 16'd0;
			timed_out_q <= 1'b0;
		end else if (accept) begin
			if (!mode) begin
				silence_q <= 16'd0;
				timed_out_q <= 1'b0;
				len_q <= end_of_chunk ? 8'd0 : len_byte;
			end else if (fire) begin
				// handled on timeout: restart silence tracking
				silence_q <= 16'd0;
				timed_out_q <= 1'b0;
				len_q <= 8'd0;
			end else if (!timed_out_q) begin
				timed_out_q <= to_next;
				if (silence_q != 16'hFFFF) begin
					silence_q <= silence_q + 16'd1;
				end
			end
		end
	end
endmodule

// ----- hw/rtl/mbrs_jobq.sv -----
// Two-entry queue of frame jobs between front and back end.
module mbrs_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mbrs_pkg::job_t din,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output mbrs_pkg::job_t dout
);
	import mbrs_pkg::*;

	job_t       mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign dout = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wptr_q <= ~wptr_q;
			if (pop && !empty) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule

// ----- hw/rtl/mbrs_back.sv -----
// Back end: checks CRC, executes read/write requests and queues reply bytes.
module mbrs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     device_address,
	input  logic [4:0]     max_read_count,
	input  logic [4:0]     readable_limit,
	input  logic           job_empty,
	input  mbrs_pkg::job_t job,
	output logic           job_pop,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     tx_byte,
	output logic           last_byte
);
	import mbrs_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CRC = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]  state_q;
	logic [7:0]  fr_q [FRAME_BYTES];
	logic [15:0] crc_q;
	logic [2:0]  idx_q;
	logic [5:0]  k_q;
	logic        is_read_q;
	logic [15:0] bank_q [BANK_REGS];

	logic [8:0]  ob_q [2];
	logic        ow_q;
	logic        or_q;
	logic [1:0]  oc_q;
	logic        ofull;

	logic [15:0] reg_a;
	logic [15:0] reg_b;
	logic [16:0] a_plus_b;
	logic        read_ok;
	logic [5:0]  n_bytes;
	logic [5:0]  rel;
	logic [16:0] r_addr;
	logic [15:0] r_val;
	logic [7:0]  e_byte;
	logic        e_last;
	logic        do_emit;

	assign reg_a = {fr_q[2], fr_q[3]};
	assign reg_b = {fr_q[4], fr_q[5]};
	assign a_plus_b = {1'b0, reg_a} + {1'b0, reg_b};
	assign read_ok = (reg_b != 16'd0) && (reg_b <= {11'd0, max_read_count})
		&& (reg_b <= 16'(MAX_REPLY_WORDS)) && (a_plus_b <= {12'd0, readable_limit});
	assign n_bytes = 6'd3 + {reg_b[4:0], 1'b0};
	assign ofull = (oc_q == 2'd2);
	assign do_emit = (state_q == ST_EMIT) && !ofull;
	assign job_pop = (state_q == ST_IDLE) && !job_empty;

	always_comb begin
		rel = k_q - 6'd3;
		r_addr = {1'b0, reg_a} + {12'd0, rel[5:1]};
		r_val = (r_addr < 17'(BANK_REGS)) ? bank_q[r_addr[BANK_AW-1:0]] : 16'd0;
		e_last = 1'b0;
		if (is_read_q) begin
			priority if (k_q == 6'd0) e_byte = device_address;
			else if (k_q == 6'd1) e_byte = FN_READ;
			else if (k_q == 6'd2) e_byte = {reg_b[6:0], 1'b0};
			else if (k_q == n_bytes) e_byte = crc_q[7:0];
			else if (k_q == n_bytes + 6'd1) begin
				e_byte = crc_q[15:8];
				e_last = 1'b1;
			end else e_byte = rel[0] ? r_val[7:0] : r_val[15:8];
		end else begin
			e_byte = fr_q[k_q[2:0]];
			e_last = (k_q == 6'(FRAME_BYTES - 1));
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			for (int i = 0; i < FRAME_BYTES; i++) begin
				fr_q[i] <= job.bytes[i*8 +: 8];
			end
		end
		if (do_emit) begin
			ob_q[ow_q] <= {e_last, e_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			crc_q <= CRC_INIT;
			idx_q <= 3'd0;
			k_q <= 6'd0;
			is_read_q <= 1'b0;
			for (int i = 0; i < BANK_REGS; i++) bank_q[i] <= 16'd0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						crc_q <= CRC_INIT;
						idx_q <= 3'd0;
						// drop short/long frames and foreign addresses
						if (job.len == 8'(FRAME_BYTES) && (job.bytes[7:0] == device_address
							|| job.bytes[7:0] == BCAST_ADDR)) begin
							state_q <= ST_CRC;
						end
					end
				end
				ST_CRC: begin
					crc_q <= crc_byte(crc_q, fr_q[idx_q]);
					idx_q <= idx_q + 3'd1;
					if (idx_q == 3'd5) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					k_q <= 6'd0;
					state_q <= ST_IDLE;
					if (crc_q == {fr_q[7], fr_q[6]}) begin
						if (fr_q[1] == FN_READ && read_ok) begin
							is_read_q <= 1'b1;
							crc_q <= CRC_INIT;
							state_q <= ST_EMIT;
						end else if (fr_q[1] == FN_WRITE) begin
							is_read_q <= 1'b0;
							if (reg_a < 16'(BANK_REGS)) bank_q[reg_a[BANK_AW-1:0]] <= reg_b;
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (do_emit) begin
						if (is_read_q && k_q < n_bytes) crc_q <= crc_byte(crc_q, e_byte);
						k_q <= k_q + 6'd1;
						if (e_last) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign empty = (oc_q == 2'd0);
	assign tx_byte = ob_q[or_q][7:0];
	assign last_byte = ob_q[or_q][8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ow_q <= 1'b0;
			or_q <= 1'b0;
			oc_q <= 2'd0;
		end else begin
			if (do_emit) ow_q <= ~ow_q;
			if (pop && !empty) or_q <= ~or_q;
			oc_q <= oc_q + 2'(do_emit) - 2'(pop && !empty);
		end
	end
endmodule

// ----- hw/rtl/modbus_rtu_slave_frame_handler.sv -----
// Top level of the Modbus RTU slave frame handler: register port and module wiring.
//
// Usage: push one request per received byte (mode 0, rx_byte, end_of_chunk)
// or per timer tick (mode 1) while full is low. Reply bytes come out of a
// queue interface: tx_byte/last_byte are valid while empty is low and are
// taken with pop. Configuration is written over the APB-style port while
// the block is idle; pready is always high.
// The front end takes one request per cycle while full is low; a request
// that completes a frame hands a job to a two-entry job queue. The back end
// takes the job, runs the request CRC over bytes 0 to 5, checks the frame
// and, if it passes, emits the reply (8 bytes for a write echo, 7 to 37 for
// a read); read bytes before the CRC go through the reply CRC. The first
// reply byte passes the job queue, the CRC and check states and the reply
// buffer; no new job is taken before the last reply byte is written. full
// rises only when the job queue holds two frames waiting for the back end.
// When the receiver stalls (pop low), the two-entry reply buffer fills and
// the back end holds; the front end keeps accepting bytes until the job
// queue is full. Reset clears lengths, timers, register bank, all queues
// and restores the register defaults.
module modbus_rtu_slave_frame_handler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_chunk,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  tx_byte,
	output logic        last_byte
);
	import mbrs_pkg::*;

	logic [7:0]  dev_addr_q;
	logic [15:0] timeout_q;
	logic [4:0]  max_read_q;
	logic [4:0]  read_lim_q;

	logic        jq_push;
	logic        jq_full;
	logic        jq_pop;
	logic        jq_empty;
	job_t        jq_din;
	job_t        jq_dout;

	assign pready = 1'b1;

	// Register file: index is the word address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= 8'd1;
			timeout_q <= 16'd3;
			max_read_q <= 5'd16;
			read_lim_q <= 5'd14;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_DEV_ADDR: dev_addr_q <= pwdata[7:0];
				REG_TIMEOUT:  timeout_q <= pwdata[15:0];
				REG_MAX_READ: max_read_q <= pwdata[4:0];
				REG_READ_LIM: read_lim_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_DEV_ADDR: prdata = {24'd0, dev_addr_q};
			REG_TIMEOUT:  prdata = {16'd0, timeout_q};
			REG_MAX_READ: prdata = {27'd0, max_read_q};
			REG_READ_LIM: prdata = {27'd0, read_lim_q};
			default:      prdata = 32'd0;
		endcase
	end

	mbrs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.device_address (dev_addr_q),
		.timeout_limit  (timeout_q),
		.push           (push),
		.full           (full),
		.mode           (mode),
		.rx_byte        (rx_byte),
		.end_of_chunk   (end_of_chunk),
		.job_push       (jq_push),
		.job            (jq_din),
		.job_full       (jq_full)
	);

	mbrs_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.din    (jq_din),
		.full   (jq_full),
		.pop    (jq_pop),
		.empty  (jq_empty),
		.dout   (jq_dout)
	);

	mbrs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.device_address (dev_addr_q),
		.max_read_count (max_read_q),
		.readable_limit (read_lim_q),
		.job_empty      (jq_empty),
		.job            (jq_dout),
		.job_pop        (jq_pop),
		.empty          (empty),
		.pop            (pop),
		.tx_byte        (tx_byte),
		.last_byte      (last_byte)
	);
endmodule
